// ----- sv/sorted_priority_queue_core_macros.svh -----
// assertion macros shared by the priority queue rtl
// needs clk_i and rst_ni in the scope where a macro is used
`ifndef SORTED_PRIORITY_QUEUE_CORE_MACROS_SVH
`define SORTED_PRIORITY_QUEUE_CORE_MACROS_SVH

// property holds on every clock edge out of reset
`define SPQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// antecedent implies consequent on the next clock edge
`define SPQ_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`endif

// ----- sv/spq_pkg.sv -----
// types and constants for the sorted priority queue
// no dependencies
package spq_pkg;

  localparam int unsigned CAPACITY_DEF = 16;
  localparam int unsigned DATA_W       = 32;
  localparam int unsigned LIVE_W       = 5;

  typedef enum logic {
    KIND_INSERT,
    KIND_REMOVE
  } kind_e;

  typedef enum logic [1:0] {
    ST_OK,
    ST_OVERFLOW,
    ST_EMPTY
  } status_e;

  typedef struct packed {
    kind_e                    kind;
    logic signed [DATA_W-1:0] value;
  } in_item_t;

  typedef struct packed {
    status_e                  status;
    logic signed [DATA_W-1:0] removed_value;
    logic [LIVE_W-1:0]        live_count;
  } out_item_t;

  // command broadcast to every cell of the row
  typedef struct packed {
    logic                     ins;
    logic                     rem;
    logic signed [DATA_W-1:0] value;
  } cell_cmd_t;

endpackage

// ----- sv/spq_cell.sv -----
// one slot of the sorted row: holds an entry, shifts right on insert, left on remove
// depends on spq_pkg
module spq_cell (
  input  logic                             clk_i,
  input  spq_pkg::cell_cmd_t               cmd_i,
  input  logic                             live_i,
  input  logic                             left_shift_i,
  input  logic signed [spq_pkg::DATA_W-1:0] left_entry_i,
  input  logic signed [spq_pkg::DATA_W-1:0] right_entry_i,
  output logic                             shift_o,
  output logic signed [spq_pkg::DATA_W-1:0] entry_o
);
  import spq_pkg::*;

  logic signed [DATA_W-1:0] entry_q, entry_d;

  // live entry not smaller than the new value moves one slot right
  assign shift_o = live_i && (entry_q >= cmd_i.value);
  assign entry_o = entry_q;

  // pick next entry from left neighbor, new value or right neighbor
  always_comb begin
    entry_d = entry_q;
    if (cmd_i.ins) begin
      if (left_shift_i) begin
        entry_d = left_entry_i;
      end else if (shift_o || !live_i) begin
        entry_d = cmd_i.value;
      end
    end else if (cmd_i.rem) begin
      entry_d = right_entry_i;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

endmodule

// ----- sv/sorted_priority_queue_core.sv -----
// sorted priority queue: one item per cycle while not stalled, result item
// registered the cycle after; every slot of the cell row compares and moves
// in parallel in the cycle the item is accepted, and the result register
// takes the item while the previous result waits only if it is being taken.
// reset clears the count and the result valid; entry slots keep no reset.
// depends on spq_pkg, spq_cell and sorted_priority_queue_core_macros.svh
`include "sorted_priority_queue_core_macros.svh"

module sorted_priority_queue_core #(
  parameter int unsigned CAPACITY = spq_pkg::CAPACITY_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  spq_pkg::in_item_t  in_item_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output spq_pkg::out_item_t out_item_o
);
  import spq_pkg::*;

  localparam int unsigned CW = $clog2(CAPACITY + 1);

  logic [CW-1:0]            count_q, count_d;
  logic                     out_valid_q;
  out_item_t                out_item_q, out_item_d;
  logic                     accept;
  logic                     full, empty;
  logic                     inc, dec;
  cell_cmd_t                cmd;
  logic [31:0]              count_ext;

  logic signed [DATA_W-1:0] entries [CAPACITY];
  logic                     shifts  [CAPACITY];
  logic                     live    [CAPACITY];

  // result register frees up when empty or being taken
  assign in_stall_o = out_valid_q && out_stall_i;
  assign accept     = in_valid_i && !in_stall_o;

  assign full  = (count_q == CW'(CAPACITY));
  assign empty = (count_q == '0);

  assign inc = accept && (in_item_i.kind == KIND_INSERT) && !full;
  assign dec = accept && (in_item_i.kind == KIND_REMOVE) && !empty;

  assign cmd.ins   = inc;
  assign cmd.rem   = dec;
  assign cmd.value = in_item_i.value;

  // row of cells
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic                     l_shift;
    logic signed [DATA_W-1:0] l_entry, r_entry;

    assign live[i] = (CW'(i) < count_q);

    if (i == 0) begin : g_first
      assign l_shift = 1'b0;
      assign l_entry = entries[i];
    end else begin : g_mid
      assign l_shift = shifts[i-1];
      assign l_entry = entries[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign r_entry = entries[i];
    end else begin : g_rest
      assign r_entry = entries[i+1];
    end

    spq_cell u_cell (
      .clk_i         (clk_i),
      .cmd_i         (cmd),
      .live_i        (live[i]),
      .left_shift_i  (l_shift),
      .left_entry_i  (l_entry),
      .right_entry_i (r_entry),
      .shift_o       (shifts[i]),
      .entry_o       (entries[i])
    );
  end

  // count update and result item
  always_comb begin
    count_d = count_q;
    if (inc) begin
      count_d = count_q + CW'(1);
    end else if (dec) begin
      count_d = count_q - CW'(1);
    end
    count_ext = 32'(count_d);

    out_item_d.status        = ST_OK;
    out_item_d.removed_value = '0;
    out_item_d.live_count    = count_ext[LIVE_W-1:0];
    if (in_item_i.kind == KIND_INSERT) begin
      if (full) begin
        out_item_d.status = ST_OVERFLOW;
      end
    end else begin
      if (empty) begin
        out_item_d.status = ST_EMPTY;
      end else begin
        out_item_d.removed_value = entries[0];
      end
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q <= count_d;
      if (accept) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_item_q <= out_item_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  // checks
  `SPQ_ASSERT(a_count_bound, count_q <= CW'(CAPACITY), "count above capacity")
  `SPQ_ASSERT(a_stall_needs_result, !in_stall_o || out_valid_q,
              "stall without pending result")
  `SPQ_ASSERT_NEXT(a_insert_counts, inc, count_q == $past(count_q) + CW'(1),
                   "insert not counted")
  `SPQ_ASSERT_NEXT(a_remove_counts, dec, count_q == $past(count_q) - CW'(1),
                   "remove not counted")
  `SPQ_ASSERT(a_empty_result,
              !(out_valid_q && out_item_q.status == ST_EMPTY) ||
              (out_item_q.removed_value == '0 && out_item_q.live_count == '0),
              "empty remove result wrong")

endmodule

// ----- tb/sorted_priority_queue_core_test.sv -----
`timescale 1ns / 1ps
// self-checking testbench for sorted_priority_queue_core: random insert/remove traffic
// with random idle on both channels, checked against a sorted-array model of the queue
// depends on spq_pkg and sorted_priority_queue_core
module sorted_priority_queue_core_test;
  import spq_pkg::*;

  localparam int unsigned CAP = CAPACITY_DEF;
  localparam int RAND_OPS = 1650;
  localparam int IDLE_LIMIT = 1000;
  localparam int DRAIN_CYCLES = 10;
  localparam logic signed [DATA_W-1:0] VAL_MIN = {1'b1, {(DATA_W-1){1'b0}}};
  localparam logic signed [DATA_W-1:0] VAL_MAX = {1'b0, {(DATA_W-1){1'b1}}};

  // ordered-queue model and the results it still expects
  class spq_result_board;
    logic signed [DATA_W-1:0] slots[CAP];
    int unsigned              held;
    out_item_t                pending_results[$];
    int                       errors;

    function new();
      held   = 0;
      errors = 0;
    endfunction

    // apply one accepted item to the model and queue its result
    function void note_op(in_item_t it);
      out_item_t   res;
      int unsigned pos;
      res.status        = ST_OK;
      res.removed_value = '0;
      if (it.kind == KIND_INSERT) begin
        if (held >= CAP) begin
          res.status = ST_OVERFLOW;
        end else begin
          // new value goes ahead of its equals
          pos = held;
          while (pos > 0 && slots[pos-1] >= it.value) begin
            slots[pos] = slots[pos-1];
            pos--;
          end
          slots[pos] = it.value;
          held++;
        end
      end else begin
        if (held == 0) begin
          res.status = ST_EMPTY;
        end else begin
          res.removed_value = slots[0];
          for (int i = 1; i < held; i++) slots[i-1] = slots[i];
          held--;
        end
      end
      res.live_count = held[LIVE_W-1:0];
      pending_results.push_back(res);
    endfunction

    // compare one result item with the oldest expected one
    function void check_result(out_item_t got);
      out_item_t want;
      if (pending_results.size() == 0) begin
        $error("result item with nothing expected: status %0d value %0d count %0d",
               got.status, got.removed_value, got.live_count);
        errors++;
        return;
      end
      want = pending_results.pop_front();
      if (got.status !== want.status) begin
        $error("status: expected %0d, actual %0d", want.status, got.status);
        errors++;
      end
      if (got.removed_value !== want.removed_value) begin
        $error("removed_value: expected %0d, actual %0d", want.removed_value,
               got.removed_value);
        errors++;
      end
      if (got.live_count !== want.live_count) begin
        $error("live_count: expected %0d, actual %0d", want.live_count, got.live_count);
        errors++;
      end
    endfunction

    function int pending();
      return pending_results.size();
    endfunction
  endclass

  logic      clk_i;
  logic      rst_ni;
  logic      in_valid_i;
  logic      in_stall_o;
  in_item_t  in_item_i;
  logic      out_valid_o;
  logic      out_stall_i;
  out_item_t out_item_o;

  spq_result_board board;
  int in_burst_left;
  int out_burst_left;
  int idle_cycles = 0;

  sorted_priority_queue_core #(
    .CAPACITY(CAP)
  ) DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_item_i  (in_item_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_item_o (out_item_o)
  );

  // 10 ns clock
  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // wait before the next item: random, with occasional runs of back-to-back items
  function automatic int draw_wait(inout int burst_left);
    if (burst_left > 0) begin
      burst_left--;
      return 0;
    end
    if ($urandom_range(19) == 0) begin
      burst_left = $urandom_range(60, 20);
      return 0;
    end
    return $urandom_range(18);
  endfunction

  // random value: mostly full range, with some near-equal values and extremes
  function automatic logic signed [DATA_W-1:0] rand_value();
    logic signed [DATA_W-1:0] v;
    case ($urandom_range(7))
      0, 1: v = $signed($urandom_range(4)) - 2;
      2: begin
        case ($urandom_range(3))
          0: v = VAL_MIN;
          1: v = VAL_MAX;
          2: v = VAL_MIN + 1;
          default: v = VAL_MAX - 1;
        endcase
      end
      default: v = $urandom;
    endcase
    return v;
  endfunction

  // hand one item to the block and wait until it is taken
  task automatic send_item(input in_item_t it);
    int gap;
    gap = draw_wait(in_burst_left);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i  <= it;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  task automatic push_value(input logic signed [DATA_W-1:0] v);
    in_item_t it;
    it.kind  = KIND_INSERT;
    it.value = v;
    send_item(it);
  endtask

  task automatic pop_min();
    in_item_t it;
    it.kind  = KIND_REMOVE;
    it.value = $urandom;
    send_item(it);
  endtask

  // receiver: random stall before each result item
  initial begin
    int hold;
    out_stall_i    = 1'b0;
    out_burst_left = 0;
    @(posedge rst_ni);
    forever begin
      hold = draw_wait(out_burst_left);
      if (hold > 0) begin
        out_stall_i <= 1'b1;
        repeat (hold) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
      do @(posedge clk_i); while (!(out_valid_o && !out_stall_i));
    end
  end

  // monitor both channels and watch for a hang
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) board.check_result(out_item_o);
      if (in_valid_i && !in_stall_o) board.note_op(in_item_i);
      if ((out_valid_o && !out_stall_i) || (in_valid_i && !in_stall_o)) begin
        idle_cycles <= 0;
      end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
        $display("sorted_priority_queue_core: mismatch");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // main sequence
  initial begin
    int done;
    int seg_len;
    int ins_pct;
    board         = new();
    in_burst_left = 0;
    in_valid_i    = 1'b0;
    in_item_i     = '0;
    rst_ni        = 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // remove from empty, extremes, equal values
    pop_min();
    push_value(VAL_MAX);
    push_value(VAL_MIN);
    push_value(0);
    push_value(-1);
    push_value(0);
    pop_min();
    pop_min();
    // fill to capacity, then insert into a full queue
    push_value(VAL_MAX);
    push_value(VAL_MIN);
    push_value(VAL_MIN);
    push_value(5);
    push_value(-5);
    push_value(0);
    push_value(VAL_MAX - 1);
    push_value(VAL_MIN + 1);
    push_value(100);
    push_value(-100);
    push_value(1);
    push_value(32'sh5555_5555);
    push_value(32'shaaaa_aaaa);
    push_value(7);
    pop_min();

    // random part: segments biased toward filling, draining or mixed traffic
    done = 0;
    while (done < RAND_OPS) begin
      seg_len = $urandom_range(80, 20);
      case ($urandom_range(2))
        0: ins_pct = 25;
        1: ins_pct = 50;
        default: ins_pct = 80;
      endcase
      for (int j = 0; j < seg_len; j++) begin
        if ($urandom_range(99) < ins_pct) push_value(rand_value());
        else pop_min();
        done++;
      end
    end
    in_valid_i <= 1'b0;

    // drain
    while (board.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (board.errors == 0 && board.pending() == 0) begin
      $display("sorted_priority_queue_core: match");
    end else begin
      $display("sorted_priority_queue_core: mismatch");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+sv
sv/spq_pkg.sv
sv/spq_cell.sv
sv/sorted_priority_queue_core.sv
tb/sorted_priority_queue_core_test.sv
